// ===== rtl/core/skbh_pkg.sv =====
`timescale 1ns / 1ps
// Package for the string key bucket hash: widths, constants, shared types
// and the hash mixing functions. Depends on nothing.
package skbh_pkg;

   localparam int unsigned HASH_W      = 32;
   localparam int unsigned KEY_W       = 8;
   localparam int unsigned INDEX_W     = 31;
   localparam int unsigned BITS_W      = 5;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;
   localparam int unsigned QUEUE_CNT_W = 3;

   localparam logic [BITS_W-1:0] MIN_BUCKET_BITS = 5'd7;
   localparam logic [KEY_W-1:0]  KEY_END         = 8'd0;
   localparam logic [HASH_W-1:0] HASH_SEED       = 32'h0000_0000;
   localparam logic [HASH_W-1:0] FMIX_C1         = 32'h85eb_ca6b;
   localparam logic [HASH_W-1:0] FMIX_C2         = 32'hc2b2_ae35;

   // Push from the front into the queue
   typedef struct packed {
      logic              valid;
      logic [HASH_W-1:0] hash;
   } skbh_push_type;

   // Queue status seen by the front, the back and the top
   typedef struct packed {
      logic                   empty;
      logic                   full;
      logic [QUEUE_CNT_W-1:0] count;
   } skbh_qstat_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_MIX_A,
      BACK_MIX_B,
      BACK_MUL1,
      BACK_MUL2,
      BACK_EMIT
   } skbh_state_type;

   // One-at-a-time absorb of one key byte
   function automatic logic [HASH_W-1:0] oaat_absorb(input logic [HASH_W-1:0] hash,
                                                      input logic [KEY_W-1:0]  key);
      logic [HASH_W-1:0] h;
      h = hash + {{(HASH_W-KEY_W){1'b0}}, key};
      h = h + (h << 10);
      h = h ^ (h >> 6);
      return h;
   endfunction

   // First half of the one-at-a-time finish
   function automatic logic [HASH_W-1:0] mix_a(input logic [HASH_W-1:0] hash);
      logic [HASH_W-1:0] h;
      h = hash + (hash << 3);
      h = h ^ (h >> 11);
      return h;
   endfunction

   // Last finish step and the first fmix32 fold
   function automatic logic [HASH_W-1:0] mix_b(input logic [HASH_W-1:0] hash);
      logic [HASH_W-1:0] h;
      h = hash + (hash << 15);
      h = h ^ (h >> 16);
      return h;
   endfunction

endpackage

// ===== rtl/core/skbh_front.sv =====
`timescale 1ns / 1ps
// Front of the string key bucket hash: accepts key bytes, absorbs them into
// the running hash and pushes the finished hash on a terminator. Uses skbh_pkg.
module skbh_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] key_byte
   input  skbh_pkg::skbh_qstat_type      qstat,
   output skbh_pkg::skbh_push_type       push
);
   import skbh_pkg::*;

   logic [HASH_W-1:0] hash_ff, hash_in;
   logic              accept;
   logic [KEY_W-1:0]  key;

   assign req_tready = !qstat.full;
   assign accept     = req_tvalid && req_tready;
   assign key        = req_tdata[KEY_W-1:0];

   assign push.valid = accept && (key == KEY_END);
   assign push.hash  = hash_ff;

   always_comb begin
      hash_in = hash_ff;
      if (accept) begin
         if (key == KEY_END) begin
            hash_in = HASH_SEED;
         end else begin
            hash_in = oaat_absorb(hash_ff, key);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= HASH_SEED;
      end else begin
         hash_ff <= hash_in;
      end
   end

endmodule

// ===== rtl/core/skbh_queue.sv =====
`timescale 1ns / 1ps
// Short hash queue between front and back of the string key bucket hash.
// Uses skbh_pkg.
module skbh_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  skbh_pkg::skbh_push_type       push,
   input  logic                          pop,
   output logic [skbh_pkg::HASH_W-1:0]   pop_data,
   output skbh_pkg::skbh_qstat_type      qstat
);
   import skbh_pkg::*;

   logic [HASH_W-1:0]      entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign qstat.count = count_ff;
   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));

   assign do_push  = push.valid && !qstat.full;
   assign do_pop   = pop && !qstat.empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.hash;
      end
   end

endmodule

// ===== rtl/core/skbh_back.sv =====
`timescale 1ns / 1ps
// Back of the string key bucket hash: finalizes one queued hash over several
// steps, masks it and holds it in the result register. Uses skbh_pkg.
module skbh_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [skbh_pkg::BITS_W-1:0]    bucket_bits,
   input  skbh_pkg::skbh_qstat_type       qstat,
   input  logic [skbh_pkg::HASH_W-1:0]    pop_data,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata    // [30:0] bucket_index
);
   import skbh_pkg::*;

   skbh_state_type     state_ff, state_in;
   logic [HASH_W-1:0]  hash_ff, hash_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic               load_out;
   logic [HASH_W-1:0]  final_hash;
   logic [BITS_W-1:0]  bits_eff;
   logic [HASH_W-1:0]  mask;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE:  if (!qstat.empty) state_in = BACK_MIX_A;
         BACK_MIX_A: state_in = BACK_MIX_B;
         BACK_MIX_B: state_in = BACK_MUL1;
         BACK_MUL1:  state_in = BACK_MUL2;
         BACK_MUL2:  state_in = BACK_EMIT;
         BACK_EMIT:  if (!rsp_valid_ff || rsp_tready) state_in = BACK_IDLE;
         default:    state_in = BACK_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      pop      = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         BACK_IDLE: pop      = !qstat.empty;
         BACK_EMIT: load_out = !rsp_valid_ff || rsp_tready;
         default: begin
            pop      = 1'b0;
            load_out = 1'b0;
         end
      endcase
   end

   // Datapath: one mixing group or one multiply per step
   always_comb begin
      hash_in = hash_ff;
      case (state_ff)
         BACK_IDLE:  if (pop) hash_in = pop_data;
         BACK_MIX_A: hash_in = mix_a(hash_ff);
         BACK_MIX_B: hash_in = mix_b(hash_ff);
         BACK_MUL1:  hash_in = hash_ff * FMIX_C1;
         BACK_MUL2:  hash_in = (hash_ff ^ (hash_ff >> 13)) * FMIX_C2;
         default:    hash_in = hash_ff;
      endcase
   end

   assign final_hash = hash_ff ^ (hash_ff >> 16);
   assign bits_eff   = (bucket_bits < MIN_BUCKET_BITS) ? MIN_BUCKET_BITS : bucket_bits;
   assign mask       = (HASH_W'(1) << bits_eff) - HASH_W'(1);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = final_hash[INDEX_W-1:0] & mask[INDEX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff      <= hash_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_index_ff};

endmodule

// ===== rtl/core/string_key_bucket_hash.sv =====
`timescale 1ns / 1ps
// Top level of the string key bucket hash: bucket size register, front,
// queue and back. Uses skbh_pkg, skbh_front, skbh_queue and skbh_back.
//
// Send a key as a stream of bytes on req_, one byte per transaction, ended by
// a zero byte. Each nonzero byte is absorbed into a 32-bit one-at-a-time hash
// in the cycle it is accepted, so bytes stream at one per cycle while the
// queue is not full. A zero byte hands the hash to a four-entry queue and
// reseeds the running hash to zero; an empty key still yields a result. The
// back finalizes one queued hash at a time (one-at-a-time finish, then the
// murmur3 fmix32 with its two 32x32 multiplies in separate steps), so a short
// key waits only when the queue fills. Each result on rsp_ is the hash masked
// to csr_wr_data bucket bits (values below 7 count as 7); write the register
// only while no key is in flight.

module string_key_bucket_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,   // [4:0] bucket_bits
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] key_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata      // [30:0] bucket_index, [31] zero
);
   import skbh_pkg::*;

   logic [BITS_W-1:0] bucket_bits_ff, bucket_bits_in;
   skbh_push_type     push;
   skbh_qstat_type    qstat;
   logic              pop;
   logic [HASH_W-1:0] pop_data;

   // Hold the bucket size until the next write
   assign bucket_bits_in = csr_wr_en ? csr_wr_data : bucket_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_bits_ff <= MIN_BUCKET_BITS;
      end else begin
         bucket_bits_ff <= bucket_bits_in;
      end
   end

   // Absorb key bytes and push finished hashes
   skbh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .qstat      (qstat),
      .push       (push)
   );

   // Decouple the byte stream from the finalizer
   skbh_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .pop_data (pop_data),
      .qstat    (qstat)
   );

   // Finalize, mask and deliver
   skbh_back u_back (
      .clock       (clock),
      .reset       (reset),
      .bucket_bits (bucket_bits_ff),
      .qstat       (qstat),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // A terminator transaction always leaves a hash waiting in the queue
   a_term_queued: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tdata == KEY_END)) |=> !qstat.empty)
      else $error("terminator did not reach the queue");

   // Queue occupancy never passes its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qstat.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count overflow");

   // With a bucket size of at most 7 bits, the index has no bits at or above bit 7
   a_index_masked: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (bucket_bits_ff <= MIN_BUCKET_BITS)) |-> (rsp_tdata[31:7] == '0))
      else $error("bucket index not masked");

   // Nothing is accepted while the queue is full
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !(req_tvalid && req_tready))
      else $error("byte accepted with queue full");

endmodule
